[rtl/mtca_pkg.sv]
// Shared types and constants for the multichannel threshold-crossing alarm.
// No dependencies; every other file imports this package.
package mtca_pkg;

  localparam int CHANNELS = 16;
  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CHAN_W   = 4;
  localparam int VAL_W    = 48;
  localparam int TIME_W   = 32;

  typedef logic [CHAN_W-1:0]       chan_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [TIME_W-1:0]       time_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [1:0]              evcnt_t;

  // One input beat
  typedef struct packed {
    chan_t channel;
    val_t  price;
    val_t  low_limit;
    val_t  high_limit;
    time_t now_s;
  } sample_t;

  // Per-channel state entry
  typedef struct packed {
    val_t prev;
    logic lo_latched;
    logic hi_latched;
  } chst_t;

  // One result beat
  typedef struct packed {
    chan_t channel;
    val_t  price;
    val_t  threshold;
    logic  crossed_high;
    time_t event_time;
    logic  last_event;
  } event_t;

  // Detector result for one sample
  typedef struct packed {
    logic   upd;
    chst_t  nxt;
    evcnt_t n;
    event_t ev0;
    event_t ev1;
  } det_t;

endpackage

[rtl/mtca_if.sv]
// Valid/ready channel interfaces for samples and alert events.
// Depends on mtca_pkg.
interface mtca_in_if import mtca_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t channel;
  val_t  price;
  val_t  low_limit;
  val_t  high_limit;
  time_t now_s;

  modport source (output valid, channel, price, low_limit, high_limit, now_s, input ready);
  modport sink   (input valid, channel, price, low_limit, high_limit, now_s, output ready);
endinterface

interface mtca_out_if import mtca_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t out_channel;
  val_t  out_price;
  val_t  out_threshold;
  logic  crossed_high;
  time_t event_time;
  logic  last_event;

  modport source (output valid, out_channel, out_price, out_threshold, crossed_high,
                  event_time, last_event, input ready);
  modport sink   (input valid, out_channel, out_price, out_threshold, crossed_high,
                  event_time, last_event, output ready);
endinterface

[rtl/multichannel_threshold_cross_alarm.sv]
// Top level of the multichannel threshold-crossing alarm.
// Depends on mtca_pkg, mtca_if, mtca_store, mtca_detect and mtca_evbuf.
//
// Samples enter an input register, are checked against the channel's stored
// previous value and latches, and their events (zero, one or two) land in a
// two-slot result register. A sample is taken every cycle as long as the
// result register can absorb its events: samples with no event or one event
// flow at one per cycle, a sample with two events hands them to the result
// port as two beats. A sample's first event reaches the output through the
// input register and then the result register. The store read and write
// happen in the same cycle, so back-to-back samples for one channel see each
// other's updates. The store is cleared by reset.
module multichannel_threshold_cross_alarm import mtca_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mtca_in_if.sink    in_ch,
  mtca_out_if.source out_ch
);

  sample_t in_r;
  logic    in_v_r;
  chst_t   st_rd;
  det_t    det;
  logic    ev_free, fire_s, st_we, ev_load;
  idx_t    idx;

  assign idx     = IDX_W'(in_r.channel);
  assign fire_s  = in_v_r && ((det.n == 2'd0) || ev_free);
  assign st_we   = fire_s && det.upd;
  assign ev_load = fire_s && (det.n != 2'd0);

  assign in_ch.ready = !in_v_r || fire_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      in_r.channel    <= in_ch.channel;
      in_r.price      <= in_ch.price;
      in_r.low_limit  <= in_ch.low_limit;
      in_r.high_limit <= in_ch.high_limit;
      in_r.now_s      <= in_ch.now_s;
    end
  end

  mtca_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (idx),
    .rd_data (st_rd),
    .we      (st_we),
    .wr_idx  (idx),
    .wr_data (det.nxt)
  );

  mtca_detect u_detect (
    .smp (in_r),
    .st  (st_rd),
    .det (det)
  );

  mtca_evbuf u_evbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (ev_load),
    .load_n   (det.n),
    .load_ev0 (det.ev0),
    .load_ev1 (det.ev1),
    .free     (ev_free),
    .out_ch   (out_ch)
  );

  // a two-event sample shows its non-final event first
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    ev_load && (det.n == 2'd2) |=> out_ch.valid && !out_ch.last_event)
    else $error("two-event sample did not present its first event");

  // a non-positive sample never touches state or emits
  a_ignore_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && (in_r.price <= 0) |-> !st_we && (det.n == 2'd0))
    else $error("non-positive sample changed state or raised an event");

  // events are only loaded when the result register has room
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ev_load |-> ev_free)
    else $error("result register overrun");

  // a non-final event is always followed by another pending event
  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last_event |=> out_ch.valid)
    else $error("non-final event not followed by its partner");

endmodule

[rtl/mtca_store.sv]
// Per-channel state store: previous value and the two alarm latches.
// One combinational read port, one write port. Depends on mtca_pkg.
module mtca_store import mtca_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  idx_t  rd_idx,
  output chst_t rd_data,
  input  logic  we,
  input  idx_t  wr_idx,
  input  chst_t wr_data
);

  chst_t st_r [CHANNELS];

  assign rd_data = st_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        st_r[i] <= '0;
      end
    end else if (we) begin
      st_r[wr_idx] <= wr_data;
    end
  end

endmodule

[rtl/mtca_detect.sv]
// Crossing detector: compares one sample against its channel's state and
// limits, produces up to two events and the next state. Depends on mtca_pkg.
module mtca_detect import mtca_pkg::*; (
  input  sample_t smp,
  input  chst_t   st,
  output det_t    det
);

  val_t  price, lo, hi, prev;
  logic  in_range, lo_en, hi_en, fire_lo, fire_hi;
  logic  lo_l_nxt, hi_l_nxt;
  event_t ev_lo, ev_hi;

  assign price = smp.price;
  assign lo    = smp.low_limit;
  assign hi    = smp.high_limit;
  assign prev  = st.prev;

  assign in_range = (32'(smp.channel) < CHANNELS);
  assign lo_en    = (lo > 0);
  assign hi_en    = (hi > 0);

  // prev of zero means the channel has not seen a sample yet
  assign fire_lo = lo_en && (prev > 0) && (prev > lo) && (price <= lo) && !st.lo_latched;
  assign fire_hi = hi_en && (prev > 0) && (prev < hi) && (price >= hi) && !st.hi_latched;

  // re-arm once the value is strictly back on the safe side
  always_comb begin
    lo_l_nxt = st.lo_latched;
    hi_l_nxt = st.hi_latched;
    if (lo_en) begin
      if (price > lo)   lo_l_nxt = 1'b0;
      else if (fire_lo) lo_l_nxt = 1'b1;
    end
    if (hi_en) begin
      if (price < hi)   hi_l_nxt = 1'b0;
      else if (fire_hi) hi_l_nxt = 1'b1;
    end
  end

  always_comb begin
    ev_lo              = '0;
    ev_lo.channel      = smp.channel;
    ev_lo.price        = price;
    ev_lo.threshold    = lo;
    ev_lo.crossed_high = 1'b0;
    ev_lo.event_time   = smp.now_s;
    ev_lo.last_event   = !fire_hi;

    ev_hi              = '0;
    ev_hi.channel      = smp.channel;
    ev_hi.price        = price;
    ev_hi.threshold    = hi;
    ev_hi.crossed_high = 1'b1;
    ev_hi.event_time   = smp.now_s;
    ev_hi.last_event   = 1'b1;
  end

  always_comb begin
    det                = '0;
    det.upd            = in_range && (price > 0);
    det.nxt.prev       = price;
    det.nxt.lo_latched = lo_l_nxt;
    det.nxt.hi_latched = hi_l_nxt;
    det.n              = det.upd ? (evcnt_t'(fire_lo) + evcnt_t'(fire_hi)) : 2'd0;
    det.ev0            = fire_lo ? ev_lo : ev_hi;
    det.ev1            = ev_hi;
  end

endmodule

[rtl/mtca_evbuf.sv]
// Two-slot result register: holds the events of one sample and hands them
// out one beat at a time. Depends on mtca_pkg and mtca_if.
module mtca_evbuf import mtca_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  evcnt_t     load_n,
  input  event_t     load_ev0,
  input  event_t     load_ev1,
  output logic       free,
  mtca_out_if.source out_ch
);

  evcnt_t cnt_r, cnt_nxt;
  event_t s0_r, s0_nxt, s1_r, s1_nxt;
  logic   take;

  assign take = (cnt_r != 2'd0) && out_ch.ready;
  // free now or after the beat that leaves this cycle
  assign free = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ch.ready);

  always_comb begin
    cnt_nxt = cnt_r;
    s0_nxt  = s0_r;
    s1_nxt  = s1_r;
    if (load) begin
      cnt_nxt = load_n;
      s0_nxt  = load_ev0;
      s1_nxt  = load_ev1;
    end else if (take) begin
      cnt_nxt = cnt_r - 2'd1;
      s0_nxt  = s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    s0_r <= s0_nxt;
    s1_r <= s1_nxt;
  end

  assign out_ch.valid         = (cnt_r != 2'd0);
  assign out_ch.out_channel   = s0_r.channel;
  assign out_ch.out_price     = s0_r.price;
  assign out_ch.out_threshold = s0_r.threshold;
  assign out_ch.crossed_high  = s0_r.crossed_high;
  assign out_ch.event_time    = s0_r.event_time;
  assign out_ch.last_event    = s0_r.last_event;

endmodule
